// File: hw/rtl/esc_pkg.sv
// Shared types and constants for the encoder speed counter.
// Event and register codes, reset values and the per-result info struct.
// No dependencies.
`timescale 1ns / 1ps

package esc_pkg;

    // Default width of the running and held counts
    localparam int COUNT_WIDTH_DEF = 16;

    // Event codes carried in the request's action field
    localparam logic [1:0] ACT_EDGE  = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_ARM   = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_INTERVAL  = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_SCALE     = 2'd2;

    // Register reset values
    localparam logic [15:0] INTERVAL_RESET  = 16'd1000;
    localparam logic [15:0] THRESHOLD_RESET = 16'd0;
    localparam logic [31:0] SCALE_RESET     = 32'd17429;

    // Output saturation limits for rpm, as magnitudes
    localparam int RPM_POS_MAX = 32767;
    localparam int RPM_NEG_MAX = 32768;

    // Per-result information that travels beside the count magnitude
    typedef struct packed {
        logic [15:0] latched;   // held count, saturated to 16-bit signed
        logic        neg;       // held count is negative
        logic        hit;       // threshold countdown reached zero
        logic        rdy;       // interval completed on this tick
    } t_res_info;

endpackage

// File: hw/rtl/esc_core.sv
// Event state of the encoder speed counter: configuration registers,
// running/held counts, countdown and interval prescaler.
// Depends on esc_pkg.
`timescale 1ns / 1ps

module esc_core
    import esc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // event request, applied when i_accept is high
    input  logic                   i_accept,
    input  logic [1:0]             i_action,
    input  logic                   i_direction,
    // configuration write
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_index,
    input  logic [31:0]            i_cfg_data,
    // result of the current request, from the updated state
    output t_res_info              o_info,
    output logic [COUNT_WIDTH-1:0] o_mag,
    output logic [31:0]            o_scale
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
    localparam int EXT_W = 33;

    logic [15:0]            r_interval;
    logic [15:0]            r_threshold;
    logic [31:0]            r_scale;
    logic [COUNT_WIDTH-1:0] r_run,  n_run;
    logic [COUNT_WIDTH-1:0] r_held, n_held;
    logic [15:0]            r_cdown, n_cdown;
    logic [15:0]            r_ticks, n_ticks;
    logic                   hit;
    logic                   rdy;
    logic [EXT_W-1:0]       held_ext;
    logic                   held_neg;

    // Compute the state after this event
    always_comb begin
        n_run   = r_run;
        n_held  = r_held;
        n_cdown = r_cdown;
        n_ticks = r_ticks;
        hit     = 1'b0;
        rdy     = 1'b0;
        case (i_action)
            ACT_EDGE: begin
                if (i_direction) begin
                    if (r_run != CNT_MAX) n_run = r_run + COUNT_WIDTH'(1);
                end else begin
                    if (r_run != CNT_MIN) n_run = r_run - COUNT_WIDTH'(1);
                end
                if (r_cdown != 16'd0) begin
                    n_cdown = r_cdown - 16'd1;
                    hit     = (r_cdown == 16'd1);
                end
            end
            ACT_TICK: begin
                if (r_ticks == 16'd1) begin
                    // interval done: reload, latch and restart the count
                    n_ticks = r_interval;
                    n_held  = r_run;
                    n_run   = '0;
                    rdy     = 1'b1;
                end else if (r_ticks != 16'd0) begin
                    n_ticks = r_ticks - 16'd1;
                end
            end
            ACT_ARM: begin
                n_cdown = r_threshold;
            end
            ACT_CLEAR: begin
                n_run  = '0;
                n_held = '0;
            end
            default: begin
                n_run = r_run;
            end
        endcase
    end

    // Saturate the held count to 16 bits and split sign and magnitude
    assign held_neg = n_held[COUNT_WIDTH-1];
    assign held_ext = {{(EXT_W-COUNT_WIDTH){held_neg}}, n_held};

    always_comb begin
        if (!held_neg && (held_ext > EXT_W'(RPM_POS_MAX))) begin
            o_info.latched = 16'h7FFF;
        end else if (held_neg && (held_ext < {{(EXT_W-16){1'b1}}, 16'h8000})) begin
            o_info.latched = 16'h8000;
        end else begin
            o_info.latched = held_ext[15:0];
        end
        o_info.neg = held_neg;
        o_info.hit = hit;
        o_info.rdy = rdy;
    end

    assign o_mag   = held_neg ? (~n_held + COUNT_WIDTH'(1)) : n_held;
    assign o_scale = r_scale;

    // Hold state; advance on each accepted request or register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval  <= INTERVAL_RESET;
            r_threshold <= THRESHOLD_RESET;
            r_scale     <= SCALE_RESET;
            r_run       <= '0;
            r_held      <= '0;
            r_cdown     <= '0;
            r_ticks     <= INTERVAL_RESET;
        end else begin
            if (i_accept) begin
                r_run   <= n_run;
                r_held  <= n_held;
                r_cdown <= n_cdown;
                r_ticks <= n_ticks;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_INTERVAL: begin
                        r_interval <= i_cfg_data[15:0];
                        r_ticks    <= i_cfg_data[15:0];
                    end
                    CFG_THRESHOLD: r_threshold <= i_cfg_data[15:0];
                    CFG_SCALE:     r_scale     <= i_cfg_data;
                    default: begin
                        r_scale <= r_scale;
                    end
                endcase
            end
        end
    end

endmodule

// File: hw/rtl/esc_rpm.sv
// Result pipeline: capture, scale multiply, and rpm saturation stages,
// each with its own valid bit so stalls collapse bubbles.
// Depends on esc_pkg.
`timescale 1ns / 1ps

module esc_rpm
    import esc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  t_res_info              i_info,
    input  logic [COUNT_WIDTH-1:0] i_mag,
    input  logic [31:0]            i_scale,
    output logic                   o_valid,
    input  logic                   i_ready,
    output t_res_info              o_info,
    output logic [15:0]            o_rpm
);

    localparam int PROD_W = COUNT_WIDTH + 32;
    localparam int Q_W    = PROD_W - 16;

    logic                   r1_valid;
    t_res_info              r1_info;
    logic [COUNT_WIDTH-1:0] r1_mag;
    logic                   r2_valid;
    t_res_info              r2_info;
    logic [PROD_W-1:0]      r2_prod;
    logic                   r3_valid;
    t_res_info              r3_info;
    logic [15:0]            r3_rpm;
    logic                   rdy1, rdy2, rdy3;
    logic [Q_W-1:0]         q;
    logic [15:0]            q_sat;
    logic [15:0]            rpm_val;

    // Each stage may load when it is empty or its successor moves
    assign rdy3    = !r3_valid || i_ready;
    assign rdy2    = !r2_valid || rdy3;
    assign rdy1    = !r1_valid || rdy2;
    assign o_ready = rdy1;

    // Drop the Q16.16 fraction and clamp to the signed 16-bit range
    assign q = r2_prod[PROD_W-1:16];
    always_comb begin
        if (!r2_info.neg && (q > Q_W'(RPM_POS_MAX))) begin
            q_sat = 16'h7FFF;
        end else if (r2_info.neg && (q > Q_W'(RPM_NEG_MAX))) begin
            q_sat = 16'h8000;
        end else begin
            q_sat = q[15:0];
        end
        rpm_val = r2_info.neg ? (~q_sat + 16'd1) : q_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            if (rdy1) r1_valid <= i_valid;
            if (rdy2) r2_valid <= r1_valid;
            if (rdy3) r3_valid <= r2_valid;
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r1_info <= i_info;
            r1_mag  <= i_mag;
        end
        if (rdy2 && r1_valid) begin
            r2_info <= r1_info;
            r2_prod <= PROD_W'(r1_mag) * PROD_W'(i_scale);
        end
        if (rdy3 && r2_valid) begin
            r3_info <= r2_info;
            r3_rpm  <= rpm_val;
        end
    end

    assign o_valid = r3_valid;
    assign o_info  = r3_info;
    assign o_rpm   = r3_rpm;

endmodule

// File: hw/rtl/encoder_speed_counter.sv
// Encoder speed counter, top level: stream ports and configuration port.
// Depends on esc_pkg, esc_core and esc_rpm.
//
// One event request (edge, tick, arm, clear) is accepted every clock cycle
// while the input is ready, and each gives one result through a capture
// stage, a 32-bit-by-count rpm multiply stage and a saturation/output stage.
// Event state is updated as the request is accepted, so back-to-back
// requests see each other's effects. Results stall independently; the
// input stays ready while any of the three result stages has room.
// Configuration writes are taken every cycle and belong to idle periods.
`timescale 1ns / 1ps

module encoder_speed_counter
    import esc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // event requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] direction, [7:1] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [15:0] latched_count, [31:16] rpm,
                                        // [32] threshold_hit, [33] ready_res,
                                        // [39:34] zero
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic                   accept;
    logic                   cfg_we;
    t_res_info              core_info;
    logic [COUNT_WIDTH-1:0] core_mag;
    logic [31:0]            scale;
    t_res_info              out_info;
    logic [15:0]            out_rpm;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign accept      = s_axis_tvalid && s_axis_tready;

    esc_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_action    (s_axis_tuser),
        .i_direction (s_axis_tdata[0]),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_info      (core_info),
        .o_mag       (core_mag),
        .o_scale     (scale)
    );

    esc_rpm #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_rpm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_info  (core_info),
        .i_mag   (core_mag),
        .i_scale (scale),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_info  (out_info),
        .o_rpm   (out_rpm)
    );

    // Pack the result fields
    assign m_axis_tdata = {6'd0, out_info.rdy, out_info.hit, out_rpm, out_info.latched};

    // An empty output stage means the whole pipeline can take a request
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output stage");

    // A single event cannot both hit the threshold and complete an interval
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[32] && m_axis_tdata[33]))
        else $error("threshold hit and interval ready on one result");

    // rpm is never positive for a negative latched count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[15]) |->
            (m_axis_tdata[31] || (m_axis_tdata[31:16] == 16'd0)))
        else $error("positive rpm for a negative count");

    // A zero count gives zero rpm
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[15:0] == 16'd0)) |-> (m_axis_tdata[31:16] == 16'd0))
        else $error("nonzero rpm for a zero count");

endmodule

// File: sim/tb_encoder_speed_counter.sv
// Self-checking testbench for encoder_speed_counter: event stream in, result stream out.
// Depends on esc_pkg and encoder_speed_counter. A local predictor checks each result;
// a directed table runs first, then random mixes, a long hold-off and rpm saturation.
`timescale 1ns / 1ps

module tb_encoder_speed_counter;
    import esc_pkg::*;

    localparam int         CYCLE_LIMIT = 400000;
    localparam int         HOLD_CYCLES = 200;
    localparam int         CHUNK_ITEMS = 115;
    localparam int         BURST_EDGES = 3;
    localparam logic [1:0] CFG_SPARE   = 2'd3;   // unmapped register index
    localparam logic signed [15:0] COUNT_MAX = 16'sh7FFF;
    localparam logic signed [15:0] COUNT_MIN = 16'sh8000;

    typedef struct packed {
        logic [15:0] latched;
        logic [15:0] rpm;
        logic        hit;
        logic        rdy;
    } t_speed_report;

    typedef struct packed {
        logic [1:0]    act;
        logic          dir;
        logic          typed;   // use the typed-in report instead of the prediction
        t_speed_report report;
    } t_event_row;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;    // [0] direction, [7:1] zero
    logic [1:0]  s_axis_tuser = ACT_EDGE; // [1:0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;           // [15:0] latched_count, [31:16] rpm,
                                         // [32] threshold_hit, [33] ready_res
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_INTERVAL;
    logic [31:0] i_cfg_data = 32'd0;

    // predictor copy of registers and counter state
    logic [15:0]        cfg_interval;
    logic [15:0]        cfg_threshold;
    logic [31:0]        cfg_scale;
    logic signed [15:0] run_count;
    logic signed [15:0] held_count;
    logic [15:0]        countdown_left;
    logic [15:0]        ticks_left;

    t_speed_report speed_reports[$];
    int            mismatches = 0;
    int            cycles = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    bit            stall_request = 1'b0;
    bit            stall_seen;
    int            stall_left;

    encoder_speed_counter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Scale a held count by the Q16.16 factor, truncate toward zero, saturate
    function automatic logic [15:0] scale_to_rpm(logic signed [15:0] cnt);
        logic signed [16:0] wide;
        logic [16:0]        mag;
        logic [63:0]        q;
        wide = cnt;
        mag = (wide < 0) ? -wide : wide;
        q = (64'(mag) * 64'(cfg_scale)) >> 16;
        if (wide < 0) begin
            if (q > 64'(RPM_NEG_MAX)) q = 64'(RPM_NEG_MAX);
            return 16'd0 - q[15:0];
        end
        if (q > 64'(RPM_POS_MAX)) q = 64'(RPM_POS_MAX);
        return q[15:0];
    endfunction

    // Apply one event to the predicted state and return its report
    function automatic t_speed_report count_event(logic [1:0] act, logic dir);
        t_speed_report r;
        r.hit = 1'b0;
        r.rdy = 1'b0;
        case (act)
            ACT_EDGE: begin
                if (dir) begin
                    if (run_count != COUNT_MAX) run_count = run_count + 16'sd1;
                end else begin
                    if (run_count != COUNT_MIN) run_count = run_count - 16'sd1;
                end
                if (countdown_left != 16'd0) begin
                    countdown_left = countdown_left - 16'd1;
                    r.hit = (countdown_left == 16'd0);
                end
            end
            ACT_TICK: begin
                if (ticks_left != 16'd0) begin
                    ticks_left = ticks_left - 16'd1;
                    if (ticks_left == 16'd0) begin
                        ticks_left = cfg_interval;
                        held_count = run_count;
                        run_count = 16'sd0;
                        r.rdy = 1'b1;
                    end
                end
            end
            ACT_ARM: countdown_left = cfg_threshold;
            default: begin
                run_count = 16'sd0;
                held_count = 16'sd0;
            end
        endcase
        r.latched = held_count;
        r.rpm = scale_to_rpm(held_count);
        return r;
    endfunction

    function automatic t_event_row make_row(logic [1:0] act, logic dir, logic typed,
                                            logic [15:0] lat, logic [15:0] rpm,
                                            logic hit, logic rdy);
        t_event_row r;
        r.act = act;
        r.dir = dir;
        r.typed = typed;
        r.report.latched = lat;
        r.report.rpm = rpm;
        r.report.hit = hit;
        r.report.rdy = rdy;
        return r;
    endfunction

    // Offer one event request, hold until taken, then maybe idle
    task automatic send_event(logic [1:0] act, logic dir, logic typed,
                              t_speed_report typed_report);
        t_speed_report predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {7'd0, dir};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = count_event(act, dir);
        speed_reports.push_back(typed ? typed_report : predicted);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_INTERVAL: begin
                cfg_interval = data[15:0];
                ticks_left = data[15:0];
            end
            CFG_THRESHOLD: cfg_threshold = data[15:0];
            CFG_SCALE:     cfg_scale = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop offering, wait for every result, let the pipeline settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (speed_reports.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic reprogram(logic [15:0] interval, logic [15:0] threshold,
                             logic [31:0] scale);
        drain();
        write_reg(CFG_INTERVAL, {16'd0, interval});
        write_reg(CFG_THRESHOLD, {16'd0, threshold});
        write_reg(CFG_SCALE, scale);
    endtask

    // Random event mix; arms and small settings keep hits and intervals frequent
    task automatic run_random_chunk();
        int         up_pct;
        int         pick;
        logic [1:0] act;
        up_pct = $urandom_range(25, 75);
        for (int i = 0; i < CHUNK_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            act = (pick < 50) ? ACT_EDGE : (pick < 75) ? ACT_TICK :
                  (pick < 87) ? ACT_ARM : ACT_CLEAR;
            send_event(act, $urandom_range(0, 99) < up_pct, 1'b0, '0);
        end
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d got %0d", $time, name,
                     $signed(want), $signed(got));
            mismatches++;
        end
    endtask

    // Receiver: random backpressure plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_seen    <= 1'b0;
            stall_left    <= 0;
        end else if (stall_request != stall_seen) begin
            stall_seen    <= stall_request;
            stall_left    <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compare each accepted result with the oldest expected report
    always @(posedge i_clk) begin : result_check
        t_speed_report want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (speed_reports.size() == 0) begin
                $display("%0t: unexpected result, expected none got %h",
                         $time, m_axis_tdata);
                mismatches++;
            end else begin
                want = speed_reports.pop_front();
                check_field("latched_count", want.latched, m_axis_tdata[15:0]);
                check_field("rpm", want.rpm, m_axis_tdata[31:16]);
                check_field("threshold_hit", {15'd0, want.hit}, {15'd0, m_axis_tdata[32]});
                check_field("ready_res", {15'd0, want.rdy}, {15'd0, m_axis_tdata[33]});
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        t_event_row rows [25];

        // interval 2, threshold 3, scale 1.0 for the directed rows
        rows[0]  = make_row(ACT_TICK,  1'b1, 1'b1, 16'd0, 16'd0, 1'b0, 1'b0);
        rows[1]  = make_row(ACT_EDGE,  1'b1, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);
        rows[2]  = make_row(ACT_EDGE,  1'b1, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);
        rows[3]  = make_row(ACT_ARM,   1'b1, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);
        rows[4]  = make_row(ACT_EDGE,  1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);
        rows[5]  = make_row(ACT_EDGE,  1'b1, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);
        rows[6]  = make_row(ACT_EDGE,  1'b1, 1'b1, 16'd0, 16'd0, 1'b1, 1'b0);
        rows[7]  = make_row(ACT_EDGE,  1'b1, 1'b1, 16'd0, 16'd0, 1'b0, 1'b0);
        rows[8]  = make_row(ACT_TICK,  1'b0, 1'b1, 16'd4, 16'd4, 1'b0, 1'b1);
        rows[9]  = make_row(ACT_EDGE,  1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);
        rows[10] = make_row(ACT_EDGE,  1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);
        rows[11] = make_row(ACT_EDGE,  1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);
        rows[12] = make_row(ACT_TICK,  1'b1, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);
        rows[13] = make_row(ACT_TICK,  1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);
        rows[14] = make_row(ACT_CLEAR, 1'b1, 1'b1, 16'd0, 16'd0, 1'b0, 1'b0);
        rows[15] = make_row(ACT_EDGE,  1'b1, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);
        rows[16] = make_row(ACT_TICK,  1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);
        rows[17] = make_row(ACT_TICK,  1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);
        rows[18] = make_row(ACT_ARM,   1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);
        rows[19] = make_row(ACT_CLEAR, 1'b0, 1'b1, 16'd0, 16'd0, 1'b0, 1'b0);
        rows[20] = make_row(ACT_EDGE,  1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);
        rows[21] = make_row(ACT_EDGE,  1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);
        rows[22] = make_row(ACT_EDGE,  1'b1, 1'b1, 16'd0, 16'd0, 1'b1, 1'b0);
        rows[23] = make_row(ACT_TICK,  1'b1, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);
        rows[24] = make_row(ACT_TICK,  1'b0, 1'b0, 16'd0, 16'd0, 1'b0, 1'b0);

        // reset values of the predictor
        cfg_interval   = INTERVAL_RESET;
        cfg_threshold  = THRESHOLD_RESET;
        cfg_scale      = SCALE_RESET;
        run_count      = 16'sd0;
        held_count     = 16'sd0;
        countdown_left = 16'd0;
        ticks_left     = INTERVAL_RESET;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender idles lightly, receiver heavily
        send_idle_pct = 26;
        recv_idle_pct = 68;
        reprogram(16'd2, 16'd3, 32'h0001_0000);
        foreach (rows[i]) send_event(rows[i].act, rows[i].dir, rows[i].typed, rows[i].report);

        reprogram(16'd1, 16'd0, 32'd0);
        write_reg(CFG_SPARE, $urandom);
        run_random_chunk();
        // zero interval disables ticks; widest threshold and scale
        reprogram(16'd0, 16'hFFFF, 32'hFFFF_FFFF);
        run_random_chunk();

        // sender idles heavily, receiver lightly
        send_idle_pct = 68;
        recv_idle_pct = 26;
        reprogram(16'hFFFF, 16'd1, $urandom_range(0, 32'h0008_0000));
        run_random_chunk();
        reprogram(16'($urandom_range(1, 12)), 16'($urandom_range(0, 8)), $urandom);
        run_random_chunk();

        // no idling; one long receiver hold-off while requests keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        reprogram(16'($urandom_range(2, 12)), 16'($urandom_range(1, 8)),
                  $urandom_range(0, 32'h0008_0000));
        stall_request <= ~stall_request;
        run_random_chunk();
        reprogram(16'($urandom_range(1, 12)), 16'($urandom_range(0, 8)),
                  $urandom_range(0, 32'h0008_0000));
        run_random_chunk();

        // latch small counts of both signs at the widest scale; rpm clamps both ways
        reprogram(16'd1, 16'hFFFF, 32'hFFFF_FFFF);
        send_event(ACT_ARM, 1'b0, 1'b0, '0);
        repeat (BURST_EDGES) send_event(ACT_EDGE, 1'b1, 1'b0, '0);
        send_event(ACT_TICK, 1'b0, 1'b0, '0);
        repeat (BURST_EDGES) send_event(ACT_EDGE, 1'b0, 1'b0, '0);
        send_event(ACT_TICK, 1'b1, 1'b0, '0);

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
